// ===== sv/ahfe_pkg.sv =====
// ----------------------------------------------------------------------------
// ahfe_pkg
// Shared types, constants and the hex digit helper of the ASCII frame encoder.
// ----------------------------------------------------------------------------
package ahfe_pkg;

    localparam int FRAG_MAX = 15;
    localparam int CNT_W    = 4;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A    = 8'h41;

    typedef enum logic [1:0] {
        CFG_POLL  = 2'd0,
        CFG_TOKEN = 2'd1,
        CFG_USER  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] poll;
        logic [7:0] token;
        logic [7:0] user;
    } t_cfg;

    // Characters produced by one input item, first character in entry 0.
    typedef struct packed {
        logic [FRAG_MAX-1:0][7:0] ch;
        logic [CNT_W-1:0]         cnt;
        logic                     tail;
    } t_frag;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] w;
        w = {4'd0, v};
        if (v > 4'd9) begin
            return w - 8'd10 + CHAR_A;
        end
        return w + CHAR_ZERO;
    endfunction

endpackage

// ===== sv/ahfe_build.sv =====
// ----------------------------------------------------------------------------
// ahfe_build
// Frame state and character list builder: turns one transfer into up to
// fifteen characters and updates checksum and byte count.
// ----------------------------------------------------------------------------
module ahfe_build (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  ahfe_pkg::t_cfg i_cfg,
    input  logic           i_action,
    input  logic [7:0]     i_hw_dest_addr,
    input  logic [7:0]     i_hw_src_addr,
    input  logic [7:0]     i_msg_type,
    input  logic [7:0]     i_src_node,
    input  logic [7:0]     i_dest_node,
    input  logic [7:0]     i_data_length,
    input  logic [7:0]     i_data_byte,
    output ahfe_pkg::t_frag o_frag
);
    import ahfe_pkg::*;

    logic [7:0]       r_sum;
    logic [7:0]       r_left;
    logic             r_emit;
    logic             r_add;
    logic [7:0]       n_sum;
    logic [7:0]       n_left;
    logic             n_emit;
    logic             n_add;
    logic             short_f;
    logic             close_f;
    logic [CNT_W-1:0] pos;
    t_frag            frag;

    assign short_f = (i_msg_type == i_cfg.poll) || (i_msg_type == i_cfg.token);

    always_comb begin
        n_sum   = r_sum;
        n_left  = r_left;
        n_emit  = r_emit;
        n_add   = r_add;
        frag    = '0;
        pos     = '0;
        close_f = 1'b0;
        if (!i_action) begin
            if (short_f) begin
                n_sum = i_hw_dest_addr + i_hw_src_addr;
            end else begin
                n_sum = i_hw_dest_addr + i_hw_src_addr + i_msg_type
                      + i_src_node + i_dest_node + i_data_length;
            end
            n_add  = !short_f;
            n_emit = (i_msg_type == i_cfg.user);
            frag.ch[0] = i_hw_dest_addr + CHAR_ZERO;
            frag.ch[1] = hex_char(i_hw_src_addr[7:4]);
            frag.ch[2] = hex_char(i_hw_src_addr[3:0]);
            frag.ch[3] = hex_char(i_msg_type[7:4]);
            frag.ch[4] = hex_char(i_msg_type[3:0]);
            if (n_emit) begin
                frag.ch[5]  = hex_char(i_src_node[7:4]);
                frag.ch[6]  = hex_char(i_src_node[3:0]);
                frag.ch[7]  = hex_char(i_dest_node[7:4]);
                frag.ch[8]  = hex_char(i_dest_node[3:0]);
                frag.ch[9]  = hex_char(i_data_length[7:4]);
                frag.ch[10] = hex_char(i_data_length[3:0]);
                n_left = i_data_length;
                pos    = CNT_W'(11);
            end else begin
                n_left = short_f ? 8'd0 : i_data_length;
                pos    = CNT_W'(5);
            end
            close_f = (n_left == 8'd0);
        end else if (r_left != 8'd0) begin
            if (r_add) begin
                n_sum = r_sum + i_data_byte;
            end
            if (r_emit) begin
                frag.ch[0] = hex_char(i_data_byte[7:4]);
                frag.ch[1] = hex_char(i_data_byte[3:0]);
                pos        = CNT_W'(2);
            end
            n_left  = r_left - 8'd1;
            close_f = (n_left == 8'd0);
        end
        if (close_f) begin
            frag.ch[pos]                = hex_char(n_sum[7:4]);
            frag.ch[CNT_W'(pos + 4'd1)] = hex_char(n_sum[3:0]);
            frag.ch[CNT_W'(pos + 4'd2)] = CHAR_CR;
            frag.ch[CNT_W'(pos + 4'd3)] = CHAR_LF;
            pos       = CNT_W'(pos + 4'd4);
            frag.tail = 1'b1;
            n_emit    = 1'b0;
            n_add     = 1'b0;
        end
        frag.cnt = pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_left <= '0;
            r_emit <= 1'b0;
            r_add  <= 1'b0;
        end else if (i_accept) begin
            r_sum  <= n_sum;
            r_left <= n_left;
            r_emit <= n_emit;
            r_add  <= n_add;
        end
    end

    assign o_frag = frag;

endmodule

// ===== sv/ahfe_serial.sv =====
// ----------------------------------------------------------------------------
// ahfe_serial
// Character buffer and output register: sends the built characters one per
// transfer and frees the buffer for the next item on its last character.
// ----------------------------------------------------------------------------
module ahfe_serial (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  ahfe_pkg::t_frag i_frag,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_char,
    output logic            o_end
);
    import ahfe_pkg::*;

    logic [FRAG_MAX-1:0][7:0] r_buf;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         r_idx;
    logic                     r_tail;
    logic                     r_out_valid;
    logic [7:0]               r_out_char;
    logic                     r_out_end;
    logic                     out_free;
    logic                     buf_has;
    logic                     is_last;
    logic                     move;

    assign out_free = !r_out_valid || !i_stall;
    assign buf_has  = (r_idx != r_cnt);
    assign is_last  = (r_idx == CNT_W'(r_cnt - 4'd1));
    assign move     = out_free && buf_has;
    assign o_ready  = !buf_has || (move && is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_cnt <= i_frag.cnt;
                r_idx <= '0;
            end else if (move) begin
                r_idx <= CNT_W'(r_idx + 4'd1);
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_buf  <= i_frag.ch;
            r_tail <= i_frag.tail;
        end
        if (move) begin
            r_out_char <= r_buf[r_idx];
            r_out_end  <= r_tail && is_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_end   = r_out_end;

endmodule

// ===== sv/ascii_hex_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_frame_encoder
// Builds ASCII hex frames with checksum and CR LF from header and data items.
//
//   channel | handshake              | payload
//   in      | i_in_valid/o_in_stall  | action, header fields, data byte
//   out     | o_out_valid/i_out_stall| char_out, frame_end
//   cfg     | i_cfg_we               | i_cfg_index, i_cfg_data
//
// Each item yields 0 to 15 characters, one per cycle from the output
// register while i_out_stall is low: a header 5, 9, 11 or 15, a data byte
// 0, 2, 4 or 6. The next item transfers in the cycle the last character
// of the previous one moves to the output register, set by the one-item
// character buffer; o_in_stall then follows i_out_stall. Reset clears
// checksum state, byte count, buffer and output valid.
// ----------------------------------------------------------------------------
module ascii_hex_frame_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_in_action,
    input  logic [7:0] i_in_hw_dest_addr,
    input  logic [7:0] i_in_hw_src_addr,
    input  logic [7:0] i_in_msg_type,
    input  logic [7:0] i_in_src_node,
    input  logic [7:0] i_in_dest_node,
    input  logic [7:0] i_in_data_length,
    input  logic [7:0] i_in_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_char_out,
    output logic       o_out_frame_end
);
    import ahfe_pkg::*;

    t_cfg  r_cfg;
    t_frag frag;
    logic  ready;
    logic  accept;

    assign o_in_stall = !ready;
    assign accept     = i_in_valid && ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll  <= 8'd0;
            r_cfg.token <= 8'd0;
            r_cfg.user  <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POLL:  r_cfg.poll  <= i_cfg_data;
                CFG_TOKEN: r_cfg.token <= i_cfg_data;
                CFG_USER:  r_cfg.user  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ahfe_build u_build (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_cfg          (r_cfg),
        .i_action       (i_in_action),
        .i_hw_dest_addr (i_in_hw_dest_addr),
        .i_hw_src_addr  (i_in_hw_src_addr),
        .i_msg_type     (i_in_msg_type),
        .i_src_node     (i_in_src_node),
        .i_dest_node    (i_in_dest_node),
        .i_data_length  (i_in_data_length),
        .i_data_byte    (i_in_data_byte),
        .o_frag         (frag)
    );

    ahfe_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_frag   (frag),
        .o_ready  (ready),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_char   (o_out_char_out),
        .o_end    (o_out_frame_end)
    );

endmodule

// ===== sv/ahfe_check.sv =====
// ----------------------------------------------------------------------------
// ahfe_check
// Port checker of the ASCII frame encoder, bound to the top level.
// ----------------------------------------------------------------------------
module ahfe_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_char_out,
    input logic       o_out_frame_end
);
    import ahfe_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_char_out)
            && $stable(o_out_frame_end))
        else $error("stalled output transfer changed");

    a_end_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_frame_end |-> o_out_char_out == CHAR_LF)
        else $error("frame end flag not on LF");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("encoder not idle after reset");

    a_cr_then_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_char_out == CHAR_CR
            && !o_out_frame_end ##1 o_out_valid && o_out_frame_end
            |-> o_out_char_out == CHAR_LF)
        else $error("frame end on a character other than LF after CR");

endmodule

bind ascii_hex_frame_encoder ahfe_check u_ahfe_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_out_char_out  (o_out_char_out),
    .o_out_frame_end (o_out_frame_end)
);

// ===== tb/ascii_hex_frame_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_frame_encoder_tb
// Self-checking bench for the ASCII hex frame encoder. A queue of header and
// data items feeds a valid/stall driver. Each accepted transfer runs through
// a local copy of the encoder's checksum and byte-count state, which queues
// the characters it should produce. A monitor compares every output transfer
// with the oldest queued character. Type registers change between phases,
// only while the block is idle. Both sides idle at random except when calm.
// ----------------------------------------------------------------------------
module ascii_hex_frame_encoder_tb;

    import ahfe_pkg::*;

    localparam logic ACT_HEADER     = 1'b0;
    localparam logic ACT_DATA       = 1'b1;
    localparam int   IDLE_PCT       = 7;
    localparam int   SETTLE_CYCLES  = 40;
    localparam int   WATCHDOG_LIMIT = 1000;
    localparam int   PHASE_ITEMS    = 62;

    typedef struct packed {
        logic       action;
        logic [7:0] hd;
        logic [7:0] hs;
        logic [7:0] ty;
        logic [7:0] sn;
        logic [7:0] dn;
        logic [7:0] ln;
        logic [7:0] db;
    } in_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } frame_char_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = CFG_POLL;
    logic [7:0] cfg_data  = 8'd0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic       in_action = ACT_HEADER;
    logic [7:0] in_hd     = 8'd0;
    logic [7:0] in_hs     = 8'd0;
    logic [7:0] in_ty     = 8'd0;
    logic [7:0] in_sn     = 8'd0;
    logic [7:0] in_dn     = 8'd0;
    logic [7:0] in_ln     = 8'd0;
    logic [7:0] in_db     = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_char;
    logic       out_frame_end;

    in_item_t    pending_items[$];
    frame_char_t frame_chars_due[$];
    in_item_t    cur_item = '0;
    t_cfg        cfg_shadow = '{poll: 8'd0, token: 8'd0, user: 8'd1};
    logic [7:0]  chk_sum     = 8'd0;
    logic [7:0]  bytes_due   = 8'd0;
    logic        hex_payload = 1'b0;
    logic        sum_payload = 1'b0;
    logic        calm        = 1'b0;
    int          errors      = 0;
    int          idle_cycles = 0;

    ascii_hex_frame_encoder uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_in_action       (in_action),
        .i_in_hw_dest_addr (in_hd),
        .i_in_hw_src_addr  (in_hs),
        .i_in_msg_type     (in_ty),
        .i_in_src_node     (in_sn),
        .i_in_dest_node    (in_dn),
        .i_in_data_length  (in_ln),
        .i_in_data_byte    (in_db),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_out_char_out    (out_char),
        .o_out_frame_end   (out_frame_end)
    );

    always #6 clk = ~clk;

    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return CHAR_ZERO + 8'(v);
        end
        return CHAR_A + 8'(v) - 8'd10;
    endfunction

    function automatic logic idle_roll();
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    task automatic push_char(input logic [7:0] c, input logic last);
        frame_chars_due.push_back('{ch: c, last: last});
    endtask

    task automatic push_hex(input logic [7:0] v);
        push_char(nibble_char(v[7:4]), 1'b0);
        push_char(nibble_char(v[3:0]), 1'b0);
    endtask

    task automatic close_frame();
        push_hex(chk_sum);
        push_char(CHAR_CR, 1'b0);
        push_char(CHAR_LF, 1'b1);
        hex_payload = 1'b0;
        sum_payload = 1'b0;
    endtask

    task automatic encode_item(input in_item_t it);
        logic short_frame;
        if (it.action == ACT_HEADER) begin
            short_frame = (it.ty == cfg_shadow.poll) || (it.ty == cfg_shadow.token);
            if (short_frame) begin
                chk_sum = it.hd + it.hs;
            end else begin
                chk_sum = it.hd + it.hs + it.ty + it.sn + it.dn + it.ln;
            end
            sum_payload = !short_frame;
            hex_payload = (it.ty == cfg_shadow.user);
            push_char(it.hd + CHAR_ZERO, 1'b0);
            push_hex(it.hs);
            push_hex(it.ty);
            if (hex_payload) begin
                push_hex(it.sn);
                push_hex(it.dn);
                push_hex(it.ln);
                bytes_due = it.ln;
            end else begin
                bytes_due = short_frame ? 8'd0 : it.ln;
            end
            if (bytes_due == 8'd0) begin
                close_frame();
            end
        end else if (bytes_due != 8'd0) begin
            if (sum_payload) begin
                chk_sum = chk_sum + it.db;
            end
            if (hex_payload) begin
                push_hex(it.db);
            end
            bytes_due = bytes_due - 8'd1;
            if (bytes_due == 8'd0) begin
                close_frame();
            end
        end
    endtask

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("%t: %s", $realtime, msg);
        end
    endtask

    function automatic in_item_t make_header(input logic [7:0] hd, hs, ty, sn, dn, ln);
        in_item_t it;
        it = '{action: ACT_HEADER, hd: hd, hs: hs, ty: ty, sn: sn, dn: dn, ln: ln,
               db: 8'($urandom)};
        return it;
    endfunction

    function automatic in_item_t make_data(input logic [7:0] db);
        in_item_t it;
        it = in_item_t'($urandom_range(0, 32'hFFFF_FFFF));
        it.hd = 8'($urandom);
        it.hs = 8'($urandom);
        it.action = ACT_DATA;
        it.db = db;
        return it;
    endfunction

    task automatic queue_frames(input int want);
        int       made;
        int       kind;
        int       n_data;
        in_item_t hdr;
        made = 0;
        while (made < want) begin
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
                pending_items.push_back(make_data(8'($urandom)));
                continue;
            end
            hdr = make_header(8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), 8'd0);
            case ($urandom_range(0, 3))
                0: hdr.ty = cfg_shadow.poll;
                1: hdr.ty = cfg_shadow.token;
                2: hdr.ty = cfg_shadow.user;
                default: ;
            endcase
            if (kind < 15) begin
                hdr.ln = 8'($urandom);
                n_data = $urandom_range(0, 3);
            end else begin
                hdr.ln = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(9, 24))
                                                      : 8'($urandom_range(0, 8));
                n_data = hdr.ln;
                if ((hdr.ty == cfg_shadow.poll || hdr.ty == cfg_shadow.token)
                        && hdr.ty != cfg_shadow.user) begin
                    n_data = 0;
                end
            end
            pending_items.push_back(hdr);
            made++;
            repeat (n_data) begin
                pending_items.push_back(make_data(8'($urandom)));
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || frame_chars_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [7:0] poll, token, user);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POLL;
        cfg_data  <= poll;
        @(posedge clk);
        cfg_index <= CFG_TOKEN;
        cfg_data  <= token;
        @(posedge clk);
        cfg_index <= CFG_USER;
        cfg_data  <= user;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_shadow = '{poll: poll, token: token, user: user};
    endtask

    always @(posedge clk) begin : driver
        logic busy;
        busy = in_valid;
        if (!rst_n) begin
            busy = 1'b0;
        end else if (in_valid && !in_stall) begin
            encode_item(cur_item);
            busy = 1'b0;
        end
        if (rst_n && !busy && pending_items.size() != 0 && !idle_roll()) begin
            cur_item = pending_items.pop_front();
            busy = 1'b1;
        end
        in_valid  <= busy;
        in_action <= cur_item.action;
        in_hd     <= cur_item.hd;
        in_hs     <= cur_item.hs;
        in_ty     <= cur_item.ty;
        in_sn     <= cur_item.sn;
        in_dn     <= cur_item.dn;
        in_ln     <= cur_item.ln;
        in_db     <= cur_item.db;
    end

    always @(posedge clk) begin : monitor
        frame_char_t due;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (frame_chars_due.size() == 0) begin
                    note_error($sformatf("unexpected char %h frame_end %b",
                                         out_char, out_frame_end));
                end else begin
                    due = frame_chars_due.pop_front();
                    if (out_char !== due.ch) begin
                        note_error($sformatf("char_out expected %h got %h", due.ch, out_char));
                    end
                    if (out_frame_end !== due.last) begin
                        note_error($sformatf("frame_end expected %b got %b",
                                             due.last, out_frame_end));
                    end
                end
            end
            out_stall <= idle_roll();
        end
    end

    always @(posedge clk) begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ascii_hex_frame_encoder_tb failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // user frame, poll frame with stray byte, summed-only data
        pending_items.push_back(make_header(8'h00, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'h02));
        pending_items.push_back(make_data(8'h00));
        pending_items.push_back(make_data(8'hFF));
        pending_items.push_back(make_header(8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h03));
        pending_items.push_back(make_data(8'h5A));
        pending_items.push_back(make_header(8'h80, 8'h7F, 8'h7E, 8'h12, 8'h34, 8'h02));
        pending_items.push_back(make_data(8'hA5));
        pending_items.push_back(make_data(8'h5A));
        pending_items.push_back(make_header(8'h09, 8'h0A, 8'h01, 8'hAB, 8'hCD, 8'h00));
        // abandon frames part way
        pending_items.push_back(make_header(8'h0A, 8'hF0, 8'h01, 8'h01, 8'h02, 8'h03));
        pending_items.push_back(make_data(8'h11));
        pending_items.push_back(make_header(8'h30, 8'h0F, 8'h01, 8'hFF, 8'hFF, 8'h01));
        pending_items.push_back(make_data(8'h22));
        pending_items.push_back(make_header(8'h41, 8'h42, 8'hFF, 8'h80, 8'h80, 8'hFF));
        pending_items.push_back(make_data(8'hEE));
        pending_items.push_back(make_header(8'hC0, 8'h3C, 8'h02, 8'h7F, 8'h01, 8'h00));
        wait_drained();

        // a type that is both short and user
        write_regs(8'hC3, 8'hFF, 8'hC3);
        pending_items.push_back(make_header(8'h7F, 8'h80, 8'hC3, 8'h55, 8'hAA, 8'h02));
        pending_items.push_back(make_data(8'hF0));
        pending_items.push_back(make_data(8'h0F));
        pending_items.push_back(make_header(8'h11, 8'h22, 8'hFF, 8'h33, 8'h44, 8'h05));
        wait_drained();

        write_regs(8'h00, 8'hFF, 8'h01);
        queue_frames(PHASE_ITEMS);
        wait_drained();

        write_regs(8'($urandom), 8'($urandom), 8'($urandom));
        calm = 1'b1;
        queue_frames(PHASE_ITEMS);
        wait_drained();
        calm = 1'b0;

        write_regs(8'hFF, 8'h00, 8'hFF);
        queue_frames(PHASE_ITEMS);
        wait_drained();

        write_regs(8'h5A, 8'h5A, 8'hA5);
        queue_frames(PHASE_ITEMS);
        wait_drained();

        if (frame_chars_due.size() != 0) begin
            note_error($sformatf("%0d characters never arrived", frame_chars_due.size()));
        end
        if (errors == 0) begin
            $display("ascii_hex_frame_encoder_tb passed");
        end else begin
            $display("ascii_hex_frame_encoder_tb failed");
        end
        $finish;
    end

endmodule

// ===== ascii_hex_frame_encoder.f =====
sv/ahfe_pkg.sv
sv/ahfe_build.sv
sv/ahfe_serial.sv
sv/ascii_hex_frame_encoder.sv
sv/ahfe_check.sv
tb/ascii_hex_frame_encoder_tb.sv
